// ===== src/rhdm_pkg.sv =====
// rhdm_pkg: shared types, moduli and the modular reduction helper for the
// rolling hash digit matcher. No dependencies.
`default_nettype none

package rhdm_pkg;

  // hash lanes and their prime moduli
  localparam int unsigned HASH_COUNT = 3;
  localparam int unsigned HASH_W     = 20;
  localparam logic [HASH_W-1:0] PRIME [HASH_COUNT] = '{20'd786433, 20'd12289, 20'd769};

  // default window depth (longest pattern)
  localparam int unsigned MAX_PATTERN_DEFAULT = 1024;

  // widths of the item fields
  localparam int unsigned OP_W    = 2;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned POS_W   = 32;

  // intermediate sums stay below (RED_STEPS + 1) * q
  localparam int unsigned SUM_W     = 26;
  localparam int unsigned RED_STEPS = 25;

  // bias that keeps the rolled sum non-negative: 15 * q covers any digit * power
  localparam int unsigned DROP_BIAS = 15;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_TEXT    = 2'd2
  } op_t;

  // v mod q for v < (RED_STEPS + 1) * q, q a constant: parallel compares
  // against the multiples of q, then one subtract
  function automatic logic [HASH_W-1:0] mod_reduce(input logic [SUM_W-1:0] v,
                                                   input logic [HASH_W-1:0] q);
    logic [SUM_W-1:0] r;
    logic [SUM_W-1:0] mult;
    r = v;
    for (int k = 1; k <= RED_STEPS; k++) begin
      mult = SUM_W'(k) * SUM_W'(q);
      if (v >= mult) begin
        r = v - mult;
      end
    end
    return r[HASH_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/rolling_hash_digit_matcher_core.sv =====
// Top level of the rolling hash digit matcher: item decode, triple rolling
// hash, window digit store and a two-entry result buffer. Uses rhdm_pkg.
//
// Usage: items (operation, digit) arrive on the item channel with
// item_valid/item_ready; match positions leave on the result channel with
// result_valid/result_ready. A clear item returns hashes and stream state to
// reset, a pattern item below the window depth extends the pattern hashes and
// restarts the text stream, and a text item rolls the text hashes through the
// window store. Once the window holds as many digits as the pattern and all
// three hashes agree, the start index of the window is sent as one result.
// Throughput is one item per cycle while the skid register is empty. A
// result is registered when its text item is accepted. The hash recurrence
// is combinational; the oldest window digit is prefetched from the window
// memory for the next item through a registered read port with write bypass.
// Reset (rst, synchronous) clears hashes, pattern length, text count and
// the result buffer; the window memory is not cleared. When the receiver
// stalls, one result waits in the output register and a second in a skid
// register; item_ready drops only while the skid register is occupied.
`default_nettype none

module rolling_hash_digit_matcher_core
  import rhdm_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output      logic               item_ready,
  input  wire logic [OP_W-1:0]    operation,
  input  wire logic [DIGIT_W-1:0] digit,
  output      logic               result_valid,
  input  wire logic               result_ready,
  output      logic [POS_W-1:0]   match_position
);

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned IDX_W = LEN_W + 1;
  localparam int unsigned PRD_W = HASH_W + DIGIT_W;

  // hash state
  logic [HASH_W-1:0] pattern_hash [HASH_COUNT];
  logic [HASH_W-1:0] text_hash [HASH_COUNT];
  logic [HASH_W-1:0] lead_power [HASH_COUNT];   // 10^pattern_length mod q
  logic [HASH_W-1:0] pattern_hash_next [HASH_COUNT];
  logic [HASH_W-1:0] text_hash_next [HASH_COUNT];
  logic [HASH_W-1:0] lead_power_next [HASH_COUNT];

  // per-lane update candidates
  logic [HASH_W-1:0] pattern_hash_upd [HASH_COUNT];
  logic [HASH_W-1:0] lead_power_upd [HASH_COUNT];
  logic [HASH_W-1:0] text_hash_roll [HASH_COUNT];

  logic [LEN_W-1:0]   pattern_length, pattern_length_next;
  logic [POS_W-1:0]   text_count, text_count_next;
  logic [PTR_W-1:0]   window_pointer, window_pointer_next;
  logic               window_full, window_full_next;

  // window memory and prefetched oldest digit
  logic [DIGIT_W-1:0] window_digits [MAX_PATTERN];
  logic [DIGIT_W-1:0] oldest_digit;
  logic [IDX_W-1:0]   oldest_sum;
  logic [PTR_W-1:0]   oldest_addr;
  logic               text_write;

  // result buffer
  logic               skid_valid;
  logic [POS_W-1:0]   skid_position;
  logic               hit;
  logic [POS_W-1:0]   hit_position;
  logic               item_accept;
  logic               result_pop;
  logic               hashes_equal;

  assign item_ready  = !skid_valid;
  assign item_accept = item_valid && item_ready;
  assign result_pop  = result_valid && result_ready;

  // per-lane hash arithmetic
  always_comb begin
    logic [SUM_W-1:0] roll_sum;
    logic [PRD_W-1:0] drop;
    for (int j = 0; j < HASH_COUNT; j++) begin
      pattern_hash_upd[j] = mod_reduce(SUM_W'(pattern_hash[j]) * SUM_W'(10)
                                       + SUM_W'(digit), PRIME[j]);
      lead_power_upd[j]   = mod_reduce(SUM_W'(lead_power[j]) * SUM_W'(10), PRIME[j]);
      // drop the oldest digit and shift in the new one in a single step
      drop = window_full ? PRD_W'(oldest_digit) * PRD_W'(lead_power[j]) : '0;
      roll_sum = SUM_W'(text_hash[j]) * SUM_W'(10) + SUM_W'(digit)
                 + SUM_W'(DROP_BIAS) * SUM_W'(PRIME[j]) - SUM_W'(drop);
      text_hash_roll[j] = mod_reduce(roll_sum, PRIME[j]);
    end
  end

  // item decode and next state
  always_comb begin
    pattern_hash_next   = pattern_hash;
    text_hash_next      = text_hash;
    lead_power_next     = lead_power;
    pattern_length_next = pattern_length;
    text_count_next     = text_count;
    window_pointer_next = window_pointer;
    window_full_next    = window_full;
    text_write          = 1'b0;
    hit                 = 1'b0;
    hashes_equal        = 1'b1;
    if (item_accept) begin
      unique case (op_t'(operation))
        OP_CLEAR: begin
          for (int j = 0; j < HASH_COUNT; j++) begin
            pattern_hash_next[j] = '0;
            text_hash_next[j]    = '0;
            lead_power_next[j]   = HASH_W'(1);
          end
          pattern_length_next = '0;
          text_count_next     = '0;
          window_pointer_next = '0;
          window_full_next    = 1'b0;
        end
        OP_PATTERN: begin
          // a pattern digit beyond the window depth is dropped
          if (pattern_length != LEN_W'(MAX_PATTERN)) begin
            pattern_hash_next   = pattern_hash_upd;
            lead_power_next     = lead_power_upd;
            pattern_length_next = pattern_length + 1'b1;
            for (int j = 0; j < HASH_COUNT; j++) begin
              text_hash_next[j] = '0;
            end
            text_count_next     = '0;
            window_pointer_next = '0;
            window_full_next    = 1'b0;
          end
        end
        OP_TEXT: begin
          text_write          = 1'b1;
          text_hash_next      = text_hash_roll;
          window_pointer_next = (window_pointer == PTR_W'(MAX_PATTERN - 1)) ? '0
                                : window_pointer + 1'b1;
          text_count_next     = text_count + 1'b1;
          if (!window_full && pattern_length != '0
              && text_count_next == POS_W'(pattern_length)) begin
            window_full_next = 1'b1;
          end
          for (int j = 0; j < HASH_COUNT; j++) begin
            if (text_hash_roll[j] != pattern_hash[j]) begin
              hashes_equal = 1'b0;
            end
          end
          hit = window_full_next && hashes_equal;
        end
        default: begin
        end
      endcase
    end
    hit_position = text_count_next - POS_W'(pattern_length);
  end

  // address of the digit leaving the window on the next text item
  always_comb begin
    oldest_sum = IDX_W'(window_pointer_next) + IDX_W'(MAX_PATTERN)
                 - IDX_W'(pattern_length_next);
    if (oldest_sum >= IDX_W'(MAX_PATTERN)) begin
      oldest_sum = oldest_sum - IDX_W'(MAX_PATTERN);
    end
    oldest_addr = oldest_sum[PTR_W-1:0];
  end

  // window memory: one write, one registered read with write bypass
  always_ff @(posedge clk) begin
    if (text_write) begin
      window_digits[window_pointer] <= digit;
    end
    if (text_write && window_pointer == oldest_addr) begin
      oldest_digit <= digit;
    end else begin
      oldest_digit <= window_digits[oldest_addr];
    end
  end

  // hash and stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < HASH_COUNT; j++) begin
        pattern_hash[j] <= '0;
        text_hash[j]    <= '0;
        lead_power[j]   <= HASH_W'(1);
      end
      pattern_length <= '0;
      text_count     <= '0;
      window_pointer <= '0;
      window_full    <= 1'b0;
    end else begin
      pattern_hash   <= pattern_hash_next;
      text_hash      <= text_hash_next;
      lead_power     <= lead_power_next;
      pattern_length <= pattern_length_next;
      text_count     <= text_count_next;
      window_pointer <= window_pointer_next;
      window_full    <= window_full_next;
    end
  end

  // result buffer: output register plus skid register, oldest first
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (result_pop) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= hit;
      end else begin
        result_valid <= hit;
      end
    end else if (!result_valid) begin
      result_valid <= hit;
    end else if (hit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (result_pop) begin
      if (skid_valid) begin
        match_position <= skid_position;
        skid_position  <= hit_position;
      end else begin
        match_position <= hit_position;
      end
    end else if (!result_valid) begin
      match_position <= hit_position;
    end else if (hit) begin
      skid_position <= hit_position;
    end
  end

`ifndef SYNTHESIS
  // the skid register only fills behind a waiting result
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> result_valid)
    else $error("skid register holds an item with the output register empty");

  // a full window needs a pattern
  assert property (@(posedge clk) disable iff (rst)
                   window_full |-> (pattern_length != '0))
    else $error("window marked full with an empty pattern");

  // an accepted pattern digit restarts the text stream
  assert property (@(posedge clk) disable iff (rst)
                   (item_accept && operation == OP_PATTERN
                    && pattern_length != LEN_W'(MAX_PATTERN))
                   |=> (text_count == '0 && window_pointer == '0 && !window_full))
    else $error("pattern digit did not restart the text stream");

  // no result without an accepted text item
  assert property (@(posedge clk) disable iff (rst)
                   (!result_valid && !item_accept) |=> !result_valid)
    else $error("result appeared without an accepted item");
`endif

endmodule

`default_nettype wire
